@@ sv/bmhd_pkg.sv @@
`default_nettype none
package bmhd_pkg;

  localparam logic [6:0] VOL_MAX = 7'd100;

  // reset values of the configuration registers
  localparam logic [15:0] DEBOUNCE_RST = 16'd50;
  localparam logic [15:0] LONG_CLICK_RST = 16'd500;
  localparam logic [15:0] DCLICK_WIN_RST = 16'd400;
  localparam logic [15:0] HOLD_TIME_RST = 16'd3000;
  localparam logic [15:0] CLICK_TMO_RST = 16'd600;
  localparam logic [6:0] VOL_INC_RST = 7'd10;
  localparam logic [6:0] START_VOL_RST = 7'd50;
  localparam logic LED_PRESENT_RST = 1'b0;

  localparam logic [7:0] TALLY_MAX = 8'd255;
  localparam logic [7:0] TALLY_UP = 8'd2;
  localparam logic [7:0] TALLY_DOWN = 8'd3;

  typedef enum logic [2:0] {
    REG_DEBOUNCE = 3'd0,
    REG_LONG_CLICK = 3'd1,
    REG_DCLICK_WIN = 3'd2,
    REG_HOLD_TIME = 3'd3,
    REG_CLICK_TMO = 3'd4,
    REG_VOL_INC = 3'd5,
    REG_START_VOL = 3'd6,
    REG_LED_PRESENT = 3'd7
  } reg_idx_t;

  typedef enum logic [1:0] {
    VCHG_NONE = 2'd0,
    VCHG_UP = 2'd1,
    VCHG_DOWN = 2'd2
  } vchg_t;

  // result item fields, highest bit first in tdata
  typedef struct packed {
    logic [7:0] clicks_pending;
    logic [1:0] volume_changed;
    logic [6:0] volume_now;
    logic led_arg;
    logic led_update;
    logic hold_confirmed;
    logic sleep_request;
  } result_t;

  function automatic logic [6:0] clamp_vol(input logic [7:0] v);
    clamp_vol = (v > {1'b0, VOL_MAX}) ? VOL_MAX : v[6:0];
  endfunction

endpackage
`default_nettype wire

@@ sv/button_multiclick_hold_detector.sv @@
`default_nettype none
// Button multi-click / long-hold detector. Each input transaction is one
// sample tick: tdata[0] is the active-low button level, tdata[32:1] a
// wrapping millisecond timestamp. Level changes are taken after the debounce
// time; a long hold arms sleep (hold_confirmed, LED off), releasing an armed
// button requests sleep (LED on), and counted short clicks change the volume
// after the click timeout (two up, three down, held within 0..100). Every
// input transaction gives exactly one result transaction. Throughput is one
// transaction per cycle while the result stream is not stalled; a tick passes
// through the input register and then the result register, and the whole tick
// update is a single pass of compare and saturating-add logic in front of the
// result register. Program the APB registers only while the stream is idle.
module button_multiclick_hold_detector (
  input wire logic clk,
  input wire logic rst,
  // input stream
  input wire logic s_axis_tvalid,
  output logic s_axis_tready,
  input wire logic [39:0] s_axis_tdata,  // button_level[0], now_ms[32:1], zero pad
  // result stream
  output logic m_axis_tvalid,
  input wire logic m_axis_tready,
  // sleep_request[0], hold_confirmed[1], led_update[2], led_arg[3],
  // volume_now[10:4], volume_changed[12:11], clicks_pending[20:13], zero pad
  output logic [23:0] m_axis_tdata,
  // configuration
  input wire logic psel,
  input wire logic penable,
  input wire logic pwrite,
  input wire logic [4:0] paddr,
  input wire logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic pready
);

  // configuration registers
  logic [15:0] debounce_time;
  logic [15:0] long_click_limit;
  logic [15:0] double_click_window;
  logic [15:0] hold_time;
  logic [15:0] click_timeout;
  logic [6:0] volume_increment;
  logic [6:0] start_volume;
  logic led_present;

  // detector state
  logic stable_level;
  logic [31:0] change_stamp;
  logic [31:0] press_stamp;
  logic [31:0] click_stamp;
  logic is_pressed;
  logic hold_seen;
  logic sleep_armed;
  logic [7:0] click_tally;
  logic [6:0] volume_level;

  // input register
  logic in_valid;
  logic in_level;
  logic [31:0] in_now;

  // result register
  bmhd_pkg::result_t result;

  logic cfg_write;
  logic advance;

  assign pready = 1'b1;
  assign cfg_write = psel & penable & pwrite;

  // move the input register into the result register when the output frees up
  assign advance = in_valid & (~m_axis_tvalid | m_axis_tready);
  assign s_axis_tready = ~in_valid | advance;
  assign m_axis_tdata = {3'b000, result};

  always_comb begin
    case (bmhd_pkg::reg_idx_t'(paddr[4:2]))
      bmhd_pkg::REG_DEBOUNCE: prdata = {16'd0, debounce_time};
      bmhd_pkg::REG_LONG_CLICK: prdata = {16'd0, long_click_limit};
      bmhd_pkg::REG_DCLICK_WIN: prdata = {16'd0, double_click_window};
      bmhd_pkg::REG_HOLD_TIME: prdata = {16'd0, hold_time};
      bmhd_pkg::REG_CLICK_TMO: prdata = {16'd0, click_timeout};
      bmhd_pkg::REG_VOL_INC: prdata = {25'd0, volume_increment};
      bmhd_pkg::REG_START_VOL: prdata = {25'd0, start_volume};
      bmhd_pkg::REG_LED_PRESENT: prdata = {31'd0, led_present};
      default: prdata = 32'd0;
    endcase
  end

  // ---------------------------------------------------------------------
  // Tick update. Three steps in order: debounced edge, hold check,
  // click evaluation. Each step sees what the one before it left.
  // ---------------------------------------------------------------------
  logic edge_ok;
  logic rel_edge;
  logic press_edge;
  logic [31:0] press_dur;
  logic [31:0] click_gap;

  logic is_pressed_next;
  logic hold_seen_next;
  logic sleep_armed_next;
  logic [7:0] click_tally_next;
  logic [31:0] press_stamp_next;
  logic [31:0] click_stamp_next;
  logic [6:0] volume_level_next;

  logic hold_fire;
  logic [31:0] held_for;
  logic eval_fire;
  logic [31:0] idle_for;

  logic sleep_req;
  logic led_upd;
  logic led_val;
  bmhd_pkg::vchg_t vchg;
  logic [7:0] vol_sum;

  assign edge_ok = (in_level != stable_level) &&
                   ((in_now - change_stamp) > {16'd0, debounce_time});
  assign press_edge = edge_ok & ~in_level;
  assign rel_edge = edge_ok & in_level;
  assign press_dur = in_now - press_stamp;
  assign click_gap = in_now - click_stamp;
  assign vol_sum = {1'b0, volume_level} + {1'b0, volume_increment};

  always_comb begin
    is_pressed_next = is_pressed;
    hold_seen_next = hold_seen;
    sleep_armed_next = sleep_armed;
    click_tally_next = click_tally;
    press_stamp_next = press_stamp;
    click_stamp_next = click_stamp;
    volume_level_next = volume_level;
    sleep_req = 1'b0;
    led_upd = 1'b0;
    led_val = 1'b0;
    vchg = bmhd_pkg::VCHG_NONE;

    // debounced edge
    if (press_edge) begin
      is_pressed_next = 1'b1;
      hold_seen_next = 1'b0;
      press_stamp_next = in_now;
    end else if (rel_edge) begin
      is_pressed_next = 1'b0;
      hold_seen_next = 1'b0;
      if (sleep_armed) begin
        sleep_req = 1'b1;
        led_upd = led_present;
        led_val = led_present;
        sleep_armed_next = 1'b0;
        click_tally_next = 8'd0;
      end else if (press_dur < {16'd0, long_click_limit}) begin
        if (click_gap < {16'd0, double_click_window}) begin
          if (click_tally < bmhd_pkg::TALLY_MAX) begin
            click_tally_next = click_tally + 8'd1;
          end
        end else begin
          click_tally_next = 8'd1;
        end
        click_stamp_next = in_now;
      end
    end

    // hold check
    held_for = in_now - press_stamp_next;
    hold_fire = is_pressed_next & ~hold_seen_next & (held_for > {16'd0, hold_time});
    if (hold_fire) begin
      hold_seen_next = 1'b1;
      sleep_armed_next = 1'b1;
      click_tally_next = 8'd0;
      if (led_present) begin
        led_upd = 1'b1;
        led_val = 1'b0;
      end
    end

    // click sequence evaluation
    idle_for = in_now - click_stamp_next;
    eval_fire = ~is_pressed_next & ~sleep_armed_next & (click_tally_next != 8'd0) &
                (idle_for > {16'd0, click_timeout});
    if (eval_fire) begin
      if (click_tally_next == bmhd_pkg::TALLY_UP) begin
        volume_level_next = bmhd_pkg::clamp_vol(vol_sum);
        vchg = bmhd_pkg::VCHG_UP;
      end else if (click_tally_next == bmhd_pkg::TALLY_DOWN) begin
        volume_level_next = (volume_level > volume_increment) ?
                            (volume_level - volume_increment) : 7'd0;
        vchg = bmhd_pkg::VCHG_DOWN;
      end
      click_tally_next = 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_time <= bmhd_pkg::DEBOUNCE_RST;
      long_click_limit <= bmhd_pkg::LONG_CLICK_RST;
      double_click_window <= bmhd_pkg::DCLICK_WIN_RST;
      hold_time <= bmhd_pkg::HOLD_TIME_RST;
      click_timeout <= bmhd_pkg::CLICK_TMO_RST;
      volume_increment <= bmhd_pkg::VOL_INC_RST;
      start_volume <= bmhd_pkg::START_VOL_RST;
      led_present <= bmhd_pkg::LED_PRESENT_RST;
      stable_level <= 1'b1;
      change_stamp <= 32'd0;
      press_stamp <= 32'd0;
      click_stamp <= 32'd0;
      is_pressed <= 1'b0;
      hold_seen <= 1'b0;
      sleep_armed <= 1'b0;
      click_tally <= 8'd0;
      volume_level <= bmhd_pkg::clamp_vol({1'b0, bmhd_pkg::START_VOL_RST});
      in_valid <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      // capture the next tick
      if (s_axis_tready) begin
        in_valid <= s_axis_tvalid;
      end
      // drop the result once taken, refill on advance
      if (advance) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end

      if (advance) begin
        if (edge_ok) begin
          change_stamp <= in_now;
          stable_level <= in_level;
        end
        is_pressed <= is_pressed_next;
        hold_seen <= hold_seen_next;
        sleep_armed <= sleep_armed_next;
        click_tally <= click_tally_next;
        press_stamp <= press_stamp_next;
        click_stamp <= click_stamp_next;
        volume_level <= volume_level_next;
      end

      // the user must make configuration writes only while the stream is idle; the block does not enforce it
      if (cfg_write) begin
        case (bmhd_pkg::reg_idx_t'(paddr[4:2]))
          bmhd_pkg::REG_DEBOUNCE: debounce_time <= pwdata[15:0];
          bmhd_pkg::REG_LONG_CLICK: long_click_limit <= pwdata[15:0];
          bmhd_pkg::REG_DCLICK_WIN: double_click_window <= pwdata[15:0];
          bmhd_pkg::REG_HOLD_TIME: hold_time <= pwdata[15:0];
          bmhd_pkg::REG_CLICK_TMO: click_timeout <= pwdata[15:0];
          bmhd_pkg::REG_VOL_INC: volume_increment <= pwdata[6:0];
          bmhd_pkg::REG_START_VOL: begin
            start_volume <= pwdata[6:0];
            volume_level <= bmhd_pkg::clamp_vol({1'b0, pwdata[6:0]});
          end
          bmhd_pkg::REG_LED_PRESENT: led_present <= pwdata[0];
          default: ;
        endcase
      end
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_level <= s_axis_tdata[0];
      in_now <= s_axis_tdata[32:1];
    end
    if (advance) begin
      result.sleep_request <= sleep_req;
      result.hold_confirmed <= hold_fire;
      result.led_update <= led_upd;
      result.led_arg <= led_val;
      result.volume_now <= volume_level_next;
      result.volume_changed <= vchg;
      result.clicks_pending <= click_tally_next;
    end
  end

endmodule
`default_nettype wire

@@ sv/bmhd_checker.sv @@
`default_nettype none
module bmhd_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic m_axis_tvalid,
  input wire logic m_axis_tready,
  input wire logic [23:0] m_axis_tdata
);

  // stalled result holds
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  a_reset_empty: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result valid right after reset");

  a_volume_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[10:4] <= bmhd_pkg::VOL_MAX) &&
                      (m_axis_tdata[12:11] != 2'd3))
    else $error("volume field out of range");

  // LED commands only come with a hold confirm or a sleep request
  a_led_cause: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[2] |-> m_axis_tdata[0] || m_axis_tdata[1])
    else $error("LED update without cause");

  a_sleep_excl: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !(m_axis_tdata[0] && m_axis_tdata[1]) &&
                      (!m_axis_tdata[3] || (m_axis_tdata[2] && m_axis_tdata[0])))
    else $error("sleep request and hold confirm disagree");

endmodule

bind button_multiclick_hold_detector bmhd_checker u_bmhd_checker (
  .clk(clk),
  .rst(rst),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata(m_axis_tdata)
);
`default_nettype wire

@@ tb/tb_top.sv @@
`timescale 1ns / 100ps
module tb_top;

  // one result transaction per tick, so a long quiet spell means a hang
  localparam int QUIET_LIMIT = 4000;
  // length of the receiver hold-off that backs up the input stream
  localparam int STALL_CYCLES = 300;

  typedef enum int {
    CFG_DEFAULT,
    CFG_SCALED,
    CFG_ZERO,
    CFG_MAX,
    CFG_TALLY
  } cfg_mode_t;

  // a typed-in result rides along with its tick when pinned is set
  typedef struct packed {
    logic pinned;
    bmhd_pkg::result_t val;
  } pin_t;

  typedef struct packed {
    logic lvl;
    logic [31:0] ms;
    logic pinned;
    bmhd_pkg::result_t val;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [39:0] s_axis_tdata = '0;  // button_level[0], now_ms[32:1], zero pad
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  // sleep_request[0], hold_confirmed[1], led_update[2], led_arg[3],
  // volume_now[10:4], volume_changed[12:11], clicks_pending[20:13], zero pad
  logic [23:0] m_axis_tdata;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [4:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  button_multiclick_hold_detector u_top (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  initial forever #1 clk = ~clk;

  // Shadow copy of the detector: registers and tick state, kept in step with
  // every accepted configuration write and input transaction.
  logic [15:0] cfg_debounce = bmhd_pkg::DEBOUNCE_RST;
  logic [15:0] cfg_long = bmhd_pkg::LONG_CLICK_RST;
  logic [15:0] cfg_window = bmhd_pkg::DCLICK_WIN_RST;
  logic [15:0] cfg_hold = bmhd_pkg::HOLD_TIME_RST;
  logic [15:0] cfg_timeout = bmhd_pkg::CLICK_TMO_RST;
  logic [6:0] cfg_step = bmhd_pkg::VOL_INC_RST;
  logic [6:0] cfg_start = bmhd_pkg::START_VOL_RST;
  logic cfg_led = bmhd_pkg::LED_PRESENT_RST;

  logic btn_stable = 1'b1;
  logic [31:0] chg_ms = '0;
  logic [31:0] press_ms = '0;
  logic [31:0] click_ms = '0;
  logic pressed = 1'b0;
  logic hold_done = 1'b0;
  logic armed = 1'b0;
  logic [7:0] tally = '0;
  logic [6:0] vol = bmhd_pkg::START_VOL_RST;

  bmhd_pkg::result_t expected_results[$];
  pin_t pin_q[$];
  stim_row_t directed_tab[$];

  int mismatch_count = 0;
  int quiet_cycles = 0;
  int tick_count = 0;
  logic no_idle = 1'b0;
  logic hold_off_req = 1'b0;
  logic [31:0] cursor = '0;

  // Advance the shadow detector by one sample tick and return its result.
  task automatic advance_detector(input logic lvl, input logic [31:0] ms,
                                  output bmhd_pkg::result_t r);
    logic [31:0] since_chg;
    logic [31:0] dur;
    logic [7:0] vsum;
    r = '0;
    since_chg = ms - chg_ms;
    if (lvl != btn_stable && since_chg > {16'd0, cfg_debounce}) begin
      chg_ms = ms;
      btn_stable = lvl;
      if (!lvl) begin
        pressed = 1'b1;
        hold_done = 1'b0;
        press_ms = ms;
      end else begin
        dur = ms - press_ms;
        pressed = 1'b0;
        hold_done = 1'b0;
        if (armed) begin
          // release after a confirmed hold: ask for sleep, LED back on
          r.sleep_request = 1'b1;
          if (cfg_led) begin
            r.led_update = 1'b1;
            r.led_arg = 1'b1;
          end
          armed = 1'b0;
          tally = '0;
        end else if (dur < {16'd0, cfg_long}) begin
          if ((ms - click_ms) < {16'd0, cfg_window}) begin
            if (tally < bmhd_pkg::TALLY_MAX) tally = tally + 8'd1;
          end else begin
            tally = 8'd1;
          end
          click_ms = ms;
        end
      end
    end

    if (pressed && !hold_done && (ms - press_ms) > {16'd0, cfg_hold}) begin
      hold_done = 1'b1;
      armed = 1'b1;
      tally = '0;
      r.hold_confirmed = 1'b1;
      if (cfg_led) r.led_update = 1'b1;
    end

    if (!pressed && !armed && tally != 8'd0 && (ms - click_ms) > {16'd0, cfg_timeout}) begin
      if (tally == bmhd_pkg::TALLY_UP) begin
        vsum = {1'b0, vol} + {1'b0, cfg_step};
        vol = (vsum > {1'b0, bmhd_pkg::VOL_MAX}) ? bmhd_pkg::VOL_MAX : vsum[6:0];
        r.volume_changed = bmhd_pkg::VCHG_UP;
      end else if (tally == bmhd_pkg::TALLY_DOWN) begin
        vol = (vol > cfg_step) ? vol - cfg_step : 7'd0;
        r.volume_changed = bmhd_pkg::VCHG_DOWN;
      end
      tally = '0;
    end

    r.volume_now = vol;
    r.clicks_pending = tally;
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatch_count++;
    $display("%0t ns: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
  endtask

  task automatic check_result(input bmhd_pkg::result_t got, input bmhd_pkg::result_t want);
    if (got.sleep_request !== want.sleep_request)
      report_mismatch("sleep_request", 32'(got.sleep_request), 32'(want.sleep_request));
    if (got.hold_confirmed !== want.hold_confirmed)
      report_mismatch("hold_confirmed", 32'(got.hold_confirmed), 32'(want.hold_confirmed));
    if (got.led_update !== want.led_update)
      report_mismatch("led_update", 32'(got.led_update), 32'(want.led_update));
    if (got.led_arg !== want.led_arg)
      report_mismatch("led_arg", 32'(got.led_arg), 32'(want.led_arg));
    if (got.volume_now !== want.volume_now)
      report_mismatch("volume_now", 32'(got.volume_now), 32'(want.volume_now));
    if (got.volume_changed !== want.volume_changed)
      report_mismatch("volume_changed", 32'(got.volume_changed), 32'(want.volume_changed));
    if (got.clicks_pending !== want.clicks_pending)
      report_mismatch("clicks_pending", 32'(got.clicks_pending), 32'(want.clicks_pending));
  endtask

  // Monitor: sample every handshake with the values from before the edge.
  always @(posedge clk) begin
    bmhd_pkg::result_t got;
    bmhd_pkg::result_t pred;
    pin_t pin;
    logic busy;
    busy = 1'b0;
    if (!rst) begin
      // mirror each register write into the shadow copy
      if (psel && penable && pwrite && pready) begin
        busy = 1'b1;
        case (bmhd_pkg::reg_idx_t'(paddr[4:2]))
          bmhd_pkg::REG_DEBOUNCE: cfg_debounce = pwdata[15:0];
          bmhd_pkg::REG_LONG_CLICK: cfg_long = pwdata[15:0];
          bmhd_pkg::REG_DCLICK_WIN: cfg_window = pwdata[15:0];
          bmhd_pkg::REG_HOLD_TIME: cfg_hold = pwdata[15:0];
          bmhd_pkg::REG_CLICK_TMO: cfg_timeout = pwdata[15:0];
          bmhd_pkg::REG_VOL_INC: cfg_step = pwdata[6:0];
          bmhd_pkg::REG_START_VOL: begin
            // a start volume write reloads the live volume, capped at 100
            cfg_start = pwdata[6:0];
            vol = (pwdata[6:0] > bmhd_pkg::VOL_MAX) ? bmhd_pkg::VOL_MAX : pwdata[6:0];
          end
          bmhd_pkg::REG_LED_PRESENT: cfg_led = pwdata[0];
          default: ;
        endcase
      end
      // input transaction: predict, or take the typed-in value if pinned
      if (s_axis_tvalid && s_axis_tready) begin
        busy = 1'b1;
        advance_detector(s_axis_tdata[0], s_axis_tdata[32:1], pred);
        pin = (pin_q.size() != 0) ? pin_q.pop_front() : '0;
        expected_results.push_back(pin.pinned ? pin.val : pred);
      end
      // result transaction: compare with the oldest expectation
      if (m_axis_tvalid && m_axis_tready) begin
        busy = 1'b1;
        got = bmhd_pkg::result_t'(m_axis_tdata[20:0]);
        if (expected_results.size() == 0)
          report_mismatch("result with nothing expected", 32'(m_axis_tdata), 32'd0);
        else
          check_result(got, expected_results.pop_front());
      end
    end
    quiet_cycles = busy ? 0 : quiet_cycles + 1;
  end

  // Watchdog: end the run when no transaction moves for too long.
  initial begin
    while (quiet_cycles < QUIET_LIMIT) @(negedge clk);
    $display("== FAIL ==");
    $finish;
  end

  // Receiver: drop tready at random, or hold it off for a long stretch on
  // request so the block fills up and stalls its input.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        m_axis_tready <= 1'b0;
        repeat (STALL_CYCLES) @(posedge clk);
        hold_off_req = 1'b0;
      end
      m_axis_tready <= no_idle || ($urandom_range(99) >= 27);
    end
  end

  function automatic stim_row_t mk_row(input logic lvl, input logic [31:0] ms,
                                       input logic pinned, input logic [20:0] val);
    mk_row = {lvl, ms, pinned, val};
  endfunction

  function automatic int pick_span(input int lo, input int hi);
    pick_span = (hi <= lo) ? lo : $urandom_range(hi, lo);
  endfunction

  // Offer one tick and hold it until the input transaction completes.
  task automatic send_tick(input logic lvl, input logic [31:0] ms,
                           input logic pinned, input bmhd_pkg::result_t val);
    if (!no_idle && $urandom_range(99) < 12) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(5, 1)) @(posedge clk);
    end
    pin_q.push_back(pin_t'({pinned, val}));
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {7'd0, ms, lvl};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    tick_count++;
  endtask

  // Hold one level for about span ms: a tick right at the change, then a
  // few more spread over the span.
  task automatic hold_level(input logic lvl, input int span);
    int n;
    logic [31:0] stride;
    n = $urandom_range(3, 1);
    stride = 32'(span / n + 1);
    cursor = cursor + 32'd1;
    send_tick(lvl, cursor, 1'b0, '0);
    repeat (n) begin
      cursor = cursor + stride;
      send_tick(lvl, cursor, 1'b0, '0);
    end
  endtask

  task automatic reg_write(input bmhd_pkg::reg_idx_t idx, input logic [31:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  // Program all registers for one phase of the run.
  task automatic program_cfg(input cfg_mode_t mode);
    logic [15:0] deb, lng, win, hld, tmo;
    logic [6:0] step, start;
    logic led;
    case (mode)
      CFG_DEFAULT: begin
        deb = bmhd_pkg::DEBOUNCE_RST; lng = bmhd_pkg::LONG_CLICK_RST;
        win = bmhd_pkg::DCLICK_WIN_RST;
        hld = bmhd_pkg::HOLD_TIME_RST; tmo = bmhd_pkg::CLICK_TMO_RST;
        step = bmhd_pkg::VOL_INC_RST; start = bmhd_pkg::START_VOL_RST; led = 1'b1;
      end
      CFG_ZERO: begin
        deb = '0; lng = '0; win = '0; hld = '0; tmo = '0;
        step = '0; start = '0; led = 1'b0;
      end
      CFG_MAX: begin
        deb = 16'hFFFF; lng = 16'hFFFF; win = 16'hFFFF; hld = 16'hFFFF; tmo = 16'hFFFF;
        step = 7'h7F; start = 7'h7F; led = 1'b1;
      end
      CFG_TALLY: begin
        // every short press counts, nothing times out for a long while
        deb = '0; lng = 16'hFFFF; win = 16'hFFFF; hld = 16'hFFFF; tmo = 16'hFFFF;
        step = 7'($urandom_range(100));
        start = 7'($urandom_range(100));
        led = 1'($urandom_range(1));
      end
      default: begin
        // small times so that gestures take a handful of ticks
        deb = 16'($urandom_range(15));
        lng = deb + 16'($urandom_range(90, 2));
        win = 16'($urandom_range(220, 10));
        hld = 16'($urandom_range(700, 60));
        tmo = 16'($urandom_range(320, 20));
        step = ($urandom_range(9) == 0) ? 7'($urandom_range(127, 101))
                                        : 7'($urandom_range(100));
        start = 7'($urandom_range(127));
        led = 1'($urandom_range(1));
      end
    endcase
    reg_write(bmhd_pkg::REG_DEBOUNCE, {16'd0, deb});
    reg_write(bmhd_pkg::REG_LONG_CLICK, {16'd0, lng});
    reg_write(bmhd_pkg::REG_DCLICK_WIN, {16'd0, win});
    reg_write(bmhd_pkg::REG_HOLD_TIME, {16'd0, hld});
    reg_write(bmhd_pkg::REG_CLICK_TMO, {16'd0, tmo});
    reg_write(bmhd_pkg::REG_VOL_INC, {25'd0, step});
    reg_write(bmhd_pkg::REG_START_VOL, {25'd0, start});
    reg_write(bmhd_pkg::REG_LED_PRESENT, {31'd0, led});
  endtask

  // Random gestures sized from the current registers: click bursts, long
  // holds, idle spells, bounce and a little pure noise.
  task automatic play_gestures(input int n);
    int stop_at, pick, deb, lng, win, hld, tmo;
    stop_at = tick_count + n;
    deb = int'(cfg_debounce);
    lng = int'(cfg_long);
    win = int'(cfg_window);
    hld = int'(cfg_hold);
    tmo = int'(cfg_timeout);
    while (tick_count < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 45) begin
        repeat ($urandom_range(4, 1)) begin
          hold_level(1'b0, pick_span(deb + 1, lng - 5));
          hold_level(1'b1, pick_span(deb + 1, win - 6));
        end
        hold_level(1'b1, pick_span(tmo + 1, tmo + tmo / 2 + 8));
      end else if (pick < 62) begin
        // long press, now and then just short of the hold time
        hold_level(1'b0, ($urandom_range(7) == 0) ? ((hld > 4) ? hld - 4 : 0)
                                                 : pick_span(hld + 1, hld + hld / 4 + 8));
        hold_level(1'b1, pick_span(deb + 1, deb + 50));
      end else if (pick < 72) begin
        hold_level(1'b1, pick_span(0, 2 * tmo + 2));
      end else if (pick < 85) begin
        // contact bounce inside the debounce time
        repeat ($urandom_range(4, 1)) hold_level(1'($urandom_range(1)), pick_span(0, deb));
      end else begin
        if ($urandom_range(1)) cursor = $urandom;
        else cursor = cursor + $urandom_range(20);
        send_tick(1'($urandom_range(1)), cursor, 1'b0, '0);
      end
    end
  endtask

  // Lower tvalid, wait until every result is back, then let the pipe settle.
  task automatic finish_phase();
    s_axis_tvalid <= 1'b0;
    @(negedge clk);
    while (expected_results.size() != 0) @(negedge clk);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    stim_row_t row;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed ticks on the reset registers: two clicks up, three clicks
    // down, bounce, a long hold and its release, timestamps across the wrap.
    directed_tab.push_back(mk_row(1'b1, 32'd0, 1'b1,
                                  {8'd0, bmhd_pkg::VCHG_NONE, 7'd50, 4'b0000}));
    directed_tab.push_back(mk_row(1'b0, 32'd100, 1'b1,
                                  {8'd0, bmhd_pkg::VCHG_NONE, 7'd50, 4'b0000}));
    directed_tab.push_back(mk_row(1'b1, 32'd200, 1'b0, '0));
    directed_tab.push_back(mk_row(1'b0, 32'd300, 1'b0, '0));
    directed_tab.push_back(mk_row(1'b1, 32'd400, 1'b0, '0));
    directed_tab.push_back(mk_row(1'b1, 32'd1100, 1'b1,
                                  {8'd0, bmhd_pkg::VCHG_UP, 7'd60, 4'b0000}));
    directed_tab.push_back(mk_row(1'b0, 32'd1200, 1'b0, '0));
    directed_tab.push_back(mk_row(1'b1, 32'd1300, 1'b0, '0));
    directed_tab.push_back(mk_row(1'b0, 32'd1400, 1'b0, '0));
    directed_tab.push_back(mk_row(1'b1, 32'd1500, 1'b0, '0));
    directed_tab.push_back(mk_row(1'b0, 32'd1600, 1'b0, '0));
    directed_tab.push_back(mk_row(1'b1, 32'd1700, 1'b0, '0));
    directed_tab.push_back(mk_row(1'b1, 32'd2400, 1'b1,
                                  {8'd0, bmhd_pkg::VCHG_DOWN, 7'd50, 4'b0000}));
    directed_tab.push_back(mk_row(1'b0, 32'd2420, 1'b0, '0));
    directed_tab.push_back(mk_row(1'b1, 32'd2440, 1'b0, '0));
    directed_tab.push_back(mk_row(1'b0, 32'd5421, 1'b1,
                                  {8'd0, bmhd_pkg::VCHG_NONE, 7'd50, 4'b0010}));
    directed_tab.push_back(mk_row(1'b0, 32'd5500, 1'b0, '0));
    directed_tab.push_back(mk_row(1'b1, 32'd5600, 1'b1,
                                  {8'd0, bmhd_pkg::VCHG_NONE, 7'd50, 4'b0001}));
    directed_tab.push_back(mk_row(1'b0, 32'hFFFF_FFF0, 1'b0, '0));
    directed_tab.push_back(mk_row(1'b1, 32'h0000_0010, 1'b0, '0));
    directed_tab.push_back(mk_row(1'b1, 32'h0000_0030, 1'b0, '0));
    directed_tab.push_back(mk_row(1'b1, 32'h0000_0400, 1'b0, '0));
    directed_tab.push_back(mk_row(1'b0, 32'hFFFF_FFFF, 1'b0, '0));
    directed_tab.push_back(mk_row(1'b1, 32'h0000_0000, 1'b0, '0));
    foreach (directed_tab[i]) begin
      row = directed_tab[i];
      send_tick(row.lvl, row.ms, row.pinned, row.val);
    end
    finish_phase();

    // small times, starting just below the timestamp wrap
    program_cfg(CFG_SCALED);
    cursor = 32'hFFFF_F000 + $urandom_range(2048);
    play_gestures(170);
    finish_phase();

    // hold off the receiver while ticks keep coming
    program_cfg(CFG_SCALED);
    cursor = $urandom;
    hold_off_req = 1'b1;
    play_gestures(170);
    finish_phase();

    // realistic millisecond times, no idling on either side
    program_cfg(CFG_DEFAULT);
    no_idle = 1'b1;
    play_gestures(170);
    finish_phase();
    no_idle = 1'b0;

    program_cfg(CFG_ZERO);
    cursor = $urandom;
    play_gestures(120);
    finish_phase();

    // all registers at their top values, start volume above 100
    program_cfg(CFG_MAX);
    cursor = $urandom;
    play_gestures(100);
    finish_phase();

    // drive the click count into saturation, then let it time out
    program_cfg(CFG_TALLY);
    cursor = $urandom;
    repeat (280) begin
      cursor = cursor + 32'd1;
      send_tick(1'b0, cursor, 1'b0, '0);
      cursor = cursor + 32'd1;
      send_tick(1'b1, cursor, 1'b0, '0);
    end
    hold_level(1'b1, 65540);
    finish_phase();

    repeat (4) begin
      program_cfg(CFG_SCALED);
      cursor = $urandom;
      play_gestures(150);
      finish_phase();
    end

    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
